FILE: rtl/core/rtsp_request_header_parser_assert.svh
// Assertion macros for the RTSP request header parser
`ifndef RTSP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define RTSP_REQUEST_HEADER_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RRHP_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RRHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RRHP_ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define RRHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rrhp_pkg.sv
// ----------------------------------------------------------------------------
// rrhp_pkg
// Types, codes and the method name table of the RTSP request parser.
// ----------------------------------------------------------------------------
package rrhp_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int NUM_NAMES   = 12;
  localparam int NAME_MAX    = 13;
  localparam int NAME_BITS   = 8 * NAME_MAX;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_BEGIN, ST_METHOD, ST_URL_START, ST_URL, ST_VER_START, ST_VER_R,
    ST_VER_RT, ST_VER_RTS, ST_VER_RTSP, ST_VER_MAJOR, ST_VER_DOT,
    ST_VER_MINOR, ST_LINE_START, ST_LINE_DONE, ST_END_START, ST_END,
    ST_FIELD, ST_VALUE_START, ST_VALUE, ST_VALUE_LINE_DONE
  } parse_state_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_BEGIN, EV_METHOD, EV_URL, EV_FIELD, EV_VALUE, EV_COMPLETE,
    EV_ERROR
  } event_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] token_length;
    logic [3:0]  method_code;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic        in_error;
  } res_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_digit;
    logic [NUM_NAMES-1:0] first;
  } cls_t;

  localparam int unsigned CH_SP    = 8'h20;
  localparam int unsigned CH_CR    = 8'h0d;
  localparam int unsigned CH_LF    = 8'h0a;
  localparam int unsigned CH_COLON = 8'h3a;

  function automatic logic [4:0] name_len(input int idx);
    case (idx)
      1: name_len = 5'd7;
      2: name_len = 5'd8;
      3: name_len = 5'd5;
      4: name_len = 5'd4;
      5: name_len = 5'd5;
      6: name_len = 5'd8;
      7: name_len = 5'd8;
      8: name_len = 5'd13;
      9: name_len = 5'd6;
      10: name_len = 5'd8;
      11: name_len = 5'd13;
      default: name_len = 5'd0;
    endcase
  endfunction

  // Method name as right-aligned bytes, last character lowest
  function automatic logic [NAME_BITS-1:0] name_bits(input int idx);
    case (idx)
      1: name_bits = NAME_BITS'("OPTIONS");
      2: name_bits = NAME_BITS'("DESCRIBE");
      3: name_bits = NAME_BITS'("SETUP");
      4: name_bits = NAME_BITS'("PLAY");
      5: name_bits = NAME_BITS'("PAUSE");
      6: name_bits = NAME_BITS'("TEARDOWN");
      7: name_bits = NAME_BITS'("ANNOUNCE");
      8: name_bits = NAME_BITS'({"GET_PARAM", "ETER"});
      9: name_bits = NAME_BITS'("RECORD");
      10: name_bits = NAME_BITS'("REDIRECT");
      11: name_bits = NAME_BITS'({"SET_PARAM", "ETER"});
      default: name_bits = '0;
    endcase
  endfunction

  // Character of a method name at a position, zero past its end
  function automatic logic [7:0] name_char(input int idx, input logic [3:0] pos);
    logic [NAME_BITS-1:0] s;
    logic [7:0] c;
    // left-align so that position p sits at a fixed byte lane
    s = name_bits(idx) << (8 * (NAME_MAX - int'(name_len(idx))));
    c = 8'h00;
    for (int p = 0; p < NAME_MAX; p++) begin
      if (pos == 4'(p)) begin
        c = s[8*(NAME_MAX-1-p) +: 8];
      end
    end
    name_char = c;
  endfunction

  function automatic logic [NUM_NAMES-1:0] first_mask(input logic [7:0] ch);
    case (ch)
      8'h4f: first_mask = 12'h002;
      8'h44: first_mask = 12'h004;
      8'h53: first_mask = 12'h808;
      8'h50: first_mask = 12'h030;
      8'h54: first_mask = 12'h040;
      8'h41: first_mask = 12'h080;
      8'h47: first_mask = 12'h100;
      8'h52: first_mask = 12'h600;
      default: first_mask = '0;
    endcase
  endfunction

endpackage

FILE: rtl/core/rrhp_if.sv
// ----------------------------------------------------------------------------
// rrhp_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface rrhp_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rrhp_front.sv
// ----------------------------------------------------------------------------
// rrhp_front
// Accepts request bytes, classifies them and pushes them into a short queue.
// ----------------------------------------------------------------------------
module rrhp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrhp_pkg::req_t in_req,
  output logic           q_valid,
  input  logic           q_ready,
  output rrhp_pkg::cls_t q_data
);
  import rrhp_pkg::*;

  cls_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QCNT_BITS-1:0] cnt_r;
  cls_t                 cls;
  logic                 push, pop;

  always_comb begin
    cls.ch       = in_req.byte_in;
    cls.restart  = in_req.restart;
    cls.is_sp    = in_req.byte_in == 8'(CH_SP);
    cls.is_cr    = in_req.byte_in == 8'(CH_CR);
    cls.is_lf    = in_req.byte_in == 8'(CH_LF);
    cls.is_colon = in_req.byte_in == 8'(CH_COLON);
    cls.is_digit = in_req.byte_in >= 8'h30 && in_req.byte_in <= 8'h39;
    cls.first    = first_mask(in_req.byte_in);
  end

  assign in_ready = cnt_r != QCNT_BITS'(QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end
endmodule

FILE: rtl/core/rrhp_back.sv
// ----------------------------------------------------------------------------
// rrhp_back
// Parse state machine and output register.
// ----------------------------------------------------------------------------
module rrhp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  rrhp_pkg::cls_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrhp_pkg::res_t out_res
);
  import rrhp_pkg::*;

  parse_state_t           state_r, state_nxt;
  logic [NUM_NAMES-1:0]   mask_r, mask_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt, count_inc;
  logic [3:0]             method_r, method_nxt, major_r, major_nxt, minor_r, minor_nxt;
  logic                   err_r, err_nxt;
  event_t                 ev;
  logic [LENGTH_BITS-1:0] len;
  logic                   err;
  logic [NUM_NAMES-1:0]   keep;
  logic [3:0]             hit;
  logic                   step;
  logic                   ovalid_r;
  res_t                   res_r;
  parse_state_t           cur;
  logic                   eflag;
  logic [7:0]             ch;

  assign q_ready   = !ovalid_r || out_ready;
  assign step      = q_valid && q_ready;
  assign out_valid = ovalid_r;
  assign out_res   = res_r;
  assign ch        = q_data.ch;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  // Method candidate pruning, all names in parallel
  always_comb begin
    keep = '0;
    hit  = 4'd0;
    for (int b = NUM_NAMES - 1; b >= 1; b--) begin
      if (mask_r[b]) begin
        if (q_data.is_sp && count_r == LENGTH_BITS'(name_len(b))) begin
          hit = 4'(b);
        end else if (count_r < LENGTH_BITS'(name_len(b)) &&
                     name_char(b, count_r[3:0]) == ch) begin
          keep[b] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cur        = q_data.restart ? ST_BEGIN : state_r;
    eflag      = q_data.restart ? 1'b0 : err_r;
    state_nxt  = cur;
    mask_nxt   = mask_r;
    count_nxt  = count_r;
    method_nxt = method_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    err_nxt    = eflag;
    ev         = EV_NONE;
    len        = '0;
    err        = 1'b0;
    if (!eflag) begin
      case (cur)
        ST_BEGIN: begin
          mask_nxt   = q_data.first;
          method_nxt = 4'd0;
          if (q_data.first == '0) begin
            err = 1'b1;
          end else begin
            ev        = EV_BEGIN;
            count_nxt = LENGTH_BITS'(1);
            state_nxt = ST_METHOD;
          end
        end
        ST_METHOD: begin
          if (hit != 4'd0) begin
            ev         = EV_METHOD;
            len        = count_r;
            method_nxt = hit;
            mask_nxt   = NUM_NAMES'(1) << hit;
            state_nxt  = ST_URL_START;
          end else if (keep == '0) begin
            mask_nxt = '0;
            err      = 1'b1;
          end else begin
            mask_nxt  = keep;
            count_nxt = count_inc;
          end
        end
        ST_URL_START: if (!q_data.is_sp) begin
          count_nxt = LENGTH_BITS'(1);
          state_nxt = ST_URL;
        end
        ST_URL: begin
          if (q_data.is_sp) begin
            ev        = EV_URL;
            len       = count_r;
            state_nxt = ST_VER_START;
          end else begin
            count_nxt = count_inc;
          end
        end
        ST_VER_START: if (!q_data.is_sp) begin
          if (ch != 8'h52) err = 1'b1;
          else state_nxt = ST_VER_R;
        end
        ST_VER_R: if (ch != 8'h54) err = 1'b1; else state_nxt = ST_VER_RT;
        ST_VER_RT: if (ch != 8'h53) err = 1'b1; else state_nxt = ST_VER_RTS;
        ST_VER_RTS: if (ch != 8'h50) err = 1'b1; else state_nxt = ST_VER_RTSP;
        ST_VER_RTSP: if (ch != 8'h2f) err = 1'b1; else state_nxt = ST_VER_MAJOR;
        ST_VER_MAJOR: begin
          if (!q_data.is_digit) err = 1'b1;
          else begin
            major_nxt = ch[3:0];
            state_nxt = ST_VER_DOT;
          end
        end
        ST_VER_DOT: if (ch != 8'h2e) err = 1'b1; else state_nxt = ST_VER_MINOR;
        ST_VER_MINOR: begin
          if (!q_data.is_digit) err = 1'b1;
          else begin
            minor_nxt = ch[3:0];
            state_nxt = ST_LINE_START;
          end
        end
        ST_LINE_START: begin
          if (q_data.is_cr) state_nxt = ST_LINE_DONE;
          else if (q_data.is_lf) state_nxt = ST_END_START;
        end
        ST_LINE_DONE, ST_VALUE_LINE_DONE: begin
          if (!q_data.is_lf) err = 1'b1;
          else state_nxt = ST_END_START;
        end
        ST_END_START: begin
          if (q_data.is_lf) begin
            ev        = EV_COMPLETE;
            state_nxt = ST_BEGIN;
          end else if (q_data.is_cr) begin
            state_nxt = ST_END;
          end else if (q_data.is_sp) begin
            err = 1'b1;
          end else begin
            count_nxt = LENGTH_BITS'(1);
            state_nxt = ST_FIELD;
          end
        end
        ST_END: begin
          if (!q_data.is_lf) err = 1'b1;
          else begin
            ev        = EV_COMPLETE;
            state_nxt = ST_BEGIN;
          end
        end
        ST_FIELD: begin
          if (q_data.is_cr || q_data.is_lf) begin
            err = 1'b1;
          end else if (q_data.is_colon) begin
            ev        = EV_FIELD;
            len       = count_r;
            state_nxt = ST_VALUE_START;
          end else begin
            count_nxt = count_inc;
          end
        end
        ST_VALUE_START: begin
          if (q_data.is_cr || q_data.is_lf) begin
            ev        = EV_VALUE;
            state_nxt = q_data.is_cr ? ST_VALUE_LINE_DONE : ST_END_START;
          end else if (!q_data.is_sp) begin
            count_nxt = LENGTH_BITS'(1);
            state_nxt = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (q_data.is_cr || q_data.is_lf) begin
            ev        = EV_VALUE;
            len       = count_r;
            state_nxt = q_data.is_cr ? ST_VALUE_LINE_DONE : ST_END_START;
          end else begin
            count_nxt = count_inc;
          end
        end
        default: err = 1'b1;
      endcase
      if (err) begin
        ev      = EV_ERROR;
        len     = '0;
        err_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r.event_res     <= ev;
      res_r.token_length  <= 16'(len);
      res_r.method_code   <= method_nxt;
      res_r.version_major <= major_nxt;
      res_r.version_minor <= minor_nxt;
      res_r.in_error      <= err_nxt;
    end
    if (!rst_n) begin
      state_r  <= ST_BEGIN;
      mask_r   <= '0;
      count_r  <= '0;
      method_r <= 4'd0;
      major_r  <= 4'd0;
      minor_r  <= 4'd0;
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (step) begin
        state_r  <= state_nxt;
        mask_r   <= mask_nxt;
        count_r  <= count_nxt;
        method_r <= method_nxt;
        major_r  <= major_nxt;
        minor_r  <= minor_nxt;
        err_r    <= err_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end
endmodule

FILE: rtl/core/rtsp_request_header_parser.sv
// ----------------------------------------------------------------------------
// rtsp_request_header_parser
// Byte-at-a-time RTSP request header parser with one event per byte.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and yields one result while the output is not
// stalled; the sustained rate is one request per clock, set by the parse state
// update in the back stage. A two-entry queue separates classification from
// parsing, and each byte passes a queue entry and then the result register.
`include "rtsp_request_header_parser_assert.svh"
module rtsp_request_header_parser (
  input logic clk,
  input logic rst_n,
  rrhp_if.sink   in_ch,
  rrhp_if.source out_ch
);
  import rrhp_pkg::*;

  logic q_valid, q_ready;
  cls_t q_data;

  rrhp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  rrhp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.data)
  );

  `RRHP_ASSERT_IMPL(a_err_event_flag, clk, rst_n, (out_ch.valid && out_ch.data.event_res == EV_ERROR) |-> out_ch.data.in_error, "error event without flag")
  `RRHP_ASSERT_IMPL(a_len_zero, clk, rst_n, (out_ch.valid && (out_ch.data.event_res == EV_NONE || out_ch.data.event_res == EV_BEGIN || out_ch.data.event_res == EV_COMPLETE || out_ch.data.event_res == EV_ERROR)) |-> out_ch.data.token_length == 16'd0, "length on non-token event")
  `RRHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "stalled result changed")
endmodule

FILE: tb/rtsp_request_header_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsp_request_header_parser_test
// Streams RTSP request bytes through the parser: well-formed requests with
// random content, corrupted requests and raw noise, under varied idling and
// a long output hold-off. Every event is checked against a cycle-free
// software copy of the parser kept in the scoreboard.
// ----------------------------------------------------------------------------
module rtsp_request_header_parser_test;
  import rrhp_pkg::*;

  class parser_scoreboard;
    res_t         expected_q[$];
    parse_state_t st;
    logic [11:0]  cand;
    logic [15:0]  cnt;
    logic [3:0]   method;
    logic [3:0]   major;
    logic [3:0]   minor;
    logic         err_flag;
    int           mismatches;
    string        names[12];
    int           lens[12];

    function new();
      names = '{"", "OPTIONS", "DESCRIBE", "SETUP", "PLAY", "PAUSE", "TEARDOWN",
                "ANNOUNCE", {"GET_PARAM", "ETER"}, "RECORD", "REDIRECT",
                {"SET_PARAM", "ETER"}};
      foreach (names[i]) lens[i] = names[i].len();
      st = ST_BEGIN; cand = '0; cnt = '0; method = '0; major = '0; minor = '0;
      err_flag = 1'b0; mismatches = 0;
    endfunction

    function logic [11:0] first_candidates(logic [7:0] c);
      logic [11:0] m;
      m = '0;
      for (int b = 1; b < 12; b++) if (names[b][0] == c) m[b] = 1'b1;
      return m;
    endfunction

    function void bump();
      if (cnt != 16'hffff) cnt++;
    endfunction

    // Advance the parser copy by one request and queue its event
    function void note_request(req_t r);
      logic [7:0]  c;
      event_t      ev;
      logic [15:0] tlen;
      logic        bad;
      logic [11:0] keep;
      int          hit;
      res_t        e;
      c = r.byte_in; ev = EV_NONE; tlen = '0; bad = 1'b0; keep = '0; hit = 0;
      if (r.restart) begin
        err_flag = 1'b0;
        st = ST_BEGIN;
      end
      if (!err_flag) begin
        case (st)
          ST_BEGIN: begin
            cand = first_candidates(c);
            method = '0;
            if (cand == '0) bad = 1'b1;
            else begin
              ev = EV_BEGIN; cnt = 16'd1; st = ST_METHOD;
            end
          end
          ST_METHOD: begin
            for (int b = 1; b < 12; b++) begin
              if (!cand[b]) continue;
              if (c == CH_SP && cnt == lens[b]) begin
                if (hit == 0) hit = b;
              end else if (cnt < lens[b] && names[b][cnt] == c) begin
                keep[b] = 1'b1;
              end
            end
            if (hit != 0) begin
              ev = EV_METHOD; tlen = cnt; method = 4'(hit);
              cand = '0; cand[hit] = 1'b1; st = ST_URL_START;
            end else if (keep == '0) begin
              cand = '0; bad = 1'b1;
            end else begin
              cand = keep; bump();
            end
          end
          ST_URL_START: if (c != CH_SP) begin cnt = 16'd1; st = ST_URL; end
          ST_URL: begin
            if (c == CH_SP) begin
              ev = EV_URL; tlen = cnt; st = ST_VER_START;
            end else bump();
          end
          ST_VER_START: begin
            if (c != CH_SP) begin
              if (c != "R") bad = 1'b1; else st = ST_VER_R;
            end
          end
          ST_VER_R:    if (c != "T") bad = 1'b1; else st = ST_VER_RT;
          ST_VER_RT:   if (c != "S") bad = 1'b1; else st = ST_VER_RTS;
          ST_VER_RTS:  if (c != "P") bad = 1'b1; else st = ST_VER_RTSP;
          ST_VER_RTSP: if (c != "/") bad = 1'b1; else st = ST_VER_MAJOR;
          ST_VER_MAJOR: begin
            if (c < "0" || c > "9") bad = 1'b1;
            else begin major = 4'(c - "0"); st = ST_VER_DOT; end
          end
          ST_VER_DOT: if (c != ".") bad = 1'b1; else st = ST_VER_MINOR;
          ST_VER_MINOR: begin
            if (c < "0" || c > "9") bad = 1'b1;
            else begin minor = 4'(c - "0"); st = ST_LINE_START; end
          end
          ST_LINE_START: begin
            if (c == CH_CR) st = ST_LINE_DONE;
            else if (c == CH_LF) st = ST_END_START;
          end
          ST_LINE_DONE, ST_VALUE_LINE_DONE: if (c != CH_LF) bad = 1'b1; else st = ST_END_START;
          ST_END_START: begin
            if (c == CH_LF) begin ev = EV_COMPLETE; st = ST_BEGIN; end
            else if (c == CH_CR) st = ST_END;
            else if (c == CH_SP) bad = 1'b1;
            else begin cnt = 16'd1; st = ST_FIELD; end
          end
          ST_END: begin
            if (c != CH_LF) bad = 1'b1;
            else begin ev = EV_COMPLETE; st = ST_BEGIN; end
          end
          ST_FIELD: begin
            if (c == CH_CR || c == CH_LF) bad = 1'b1;
            else if (c == CH_COLON) begin ev = EV_FIELD; tlen = cnt; st = ST_VALUE_START; end
            else bump();
          end
          ST_VALUE_START: begin
            if (c == CH_CR || c == CH_LF) begin
              ev = EV_VALUE; tlen = '0;
              st = (c == CH_CR) ? ST_VALUE_LINE_DONE : ST_END_START;
            end else if (c != CH_SP) begin
              cnt = 16'd1; st = ST_VALUE;
            end
          end
          ST_VALUE: begin
            if (c == CH_CR || c == CH_LF) begin
              ev = EV_VALUE; tlen = cnt;
              st = (c == CH_CR) ? ST_VALUE_LINE_DONE : ST_END_START;
            end else bump();
          end
          default: bad = 1'b1;
        endcase
        if (bad) begin
          ev = EV_ERROR; tlen = '0; err_flag = 1'b1;
        end
      end
      e.event_res = ev; e.token_length = tlen; e.method_code = method;
      e.version_major = major; e.version_minor = minor; e.in_error = err_flag;
      expected_q.push_back(e);
    endfunction

    function void check_event(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.event_res !== e.event_res || got.token_length !== e.token_length ||
          got.method_code !== e.method_code || got.version_major !== e.version_major ||
          got.version_minor !== e.version_minor || got.in_error !== e.in_error) begin
        mismatches++;
        if (mismatches <= 10) $display("event mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  rrhp_if #(.T(req_t)) in_if();
  rrhp_if #(.T(res_t)) out_if();

  rtsp_request_header_parser dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  parser_scoreboard sb = new();
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_go = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  bytes_sent = 0;
  logic [7:0] req_bytes[$];

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_request(in_if.data);
    if (rst_n && out_if.valid && out_if.ready) sb.check_event(out_if.data);
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 300;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, logic r);
    req_t d;
    d.byte_in = b; d.restart = r;
    in_if.valid <= 1'b1;
    in_if.data <= d;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task automatic push_eol();
    if ($urandom_range(3) == 0) req_bytes.push_back(8'(CH_LF));
    else begin req_bytes.push_back(8'(CH_CR)); req_bytes.push_back(8'(CH_LF)); end
  endtask

  // Assemble one request; with corrupt set, damage one byte
  task automatic build_request(bit corrupt);
    int nf;
    req_bytes.delete();
    push_text(sb.names[$urandom_range(1, 11)]);
    repeat ($urandom_range(1, 2)) req_bytes.push_back(8'(CH_SP));
    repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom_range(33, 126)));
    repeat ($urandom_range(1, 2)) req_bytes.push_back(8'(CH_SP));
    push_text("RTSP/");
    req_bytes.push_back(8'($urandom_range(48, 57)));
    req_bytes.push_back(".");
    req_bytes.push_back(8'($urandom_range(48, 57)));
    // ignore trailing junk on the version line
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) req_bytes.push_back("x");
    push_eol();
    nf = $urandom_range(0, 3);
    repeat (nf) begin
      req_bytes.push_back(8'($urandom_range(33, 57)));
      repeat ($urandom_range(0, 8)) req_bytes.push_back(8'($urandom_range(59, 255)));
      req_bytes.push_back(8'(CH_COLON));
      repeat ($urandom_range(0, 2)) req_bytes.push_back(8'(CH_SP));
      if ($urandom_range(4) != 0)
        repeat ($urandom_range(1, 10)) req_bytes.push_back(8'($urandom_range(14, 255)));
      push_eol();
    end
    push_eol();
    if (corrupt) req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
  endtask

  task automatic send_queue(bit first_restart);
    foreach (req_bytes[i]) send_byte(req_bytes[i], (i == 0) ? first_restart : 1'b0);
  endtask

  task automatic send_text(string s, logic r);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], (i == 0) ? r : 1'b0);
  endtask

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int base_sent;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every method, empty value, bare LF lines, errors, sticky error
    for (int m = 1; m < 12; m++) begin
      req_bytes.delete();
      push_text({sb.names[m], " /a RTSP/1.0"});
      req_bytes.push_back(8'(CH_CR)); req_bytes.push_back(8'(CH_LF));
      push_text("K:");
      req_bytes.push_back(8'(CH_CR)); req_bytes.push_back(8'(CH_LF));
      push_text("C: 9");
      req_bytes.push_back(8'(CH_LF)); req_bytes.push_back(8'(CH_LF));
      send_queue(1'b0);
    end
    send_text("PLAX", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("PLA", 1'b1);
    send_byte(8'h00, 1'b0);
    send_text("PLA ", 1'b1);
    send_text("Z", 1'b1);
    send_text("SETUP u RTSP/9.9zz", 1'b1);
    send_byte(8'(CH_CR), 1'b0);
    send_byte(8'(CH_LF), 1'b0);
    send_byte(8'(CH_SP), 1'b0);
    send_text("SETUP u Q", 1'b1);
    send_text("SETUP u RTSP/a", 1'b1);
    send_text("SETUP u RTSP/1,", 1'b1);
    send_text("SETUP u RTSP/1.0", 1'b1);
    send_byte(8'(CH_LF), 1'b0);
    send_text("H", 1'b0);
    send_byte(8'(CH_LF), 1'b0);

    base_sent = bytes_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 0) hold_go = 1'b1;
      while (bytes_sent < base_sent + (ph + 1) * 250) begin
        case ($urandom_range(9))
          0: repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
          1, 2: begin build_request(1'b1); send_queue(1'($urandom_range(1))); end
          default: begin build_request(1'b0); send_queue(1'b1); end
        endcase
      end
    end
    in_if.valid <= 1'b0;
    stall_pct = 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
